// ===== hw/rtl/sts_pkg.sv =====
// ---------------------------------------------------------------------------
// Source token scanner package
// Beat types, token codes and fixed field widths shared by the scanner files.
// ---------------------------------------------------------------------------
package sts_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int MAX_RESULTS = 3;

  localparam logic [6:0] TK_EOF    = 7'd0;
  localparam logic [6:0] TK_ERROR  = 7'd1;
  localparam logic [6:0] TK_IDENT  = 7'd2;
  localparam logic [6:0] TK_INT    = 7'd3;
  localparam logic [6:0] TK_CHR    = 7'd4;
  localparam logic [6:0] TK_STR    = 7'd5;
  localparam logic [6:0] TK_KW0    = 7'd6;
  localparam logic [6:0] TK_ADD_AS = 7'd30;
  localparam logic [6:0] TK_PLUS   = 7'd31;
  localparam logic [6:0] TK_SUB_AS = 7'd32;
  localparam logic [6:0] TK_ARROW  = 7'd33;
  localparam logic [6:0] TK_MINUS  = 7'd34;
  localparam logic [6:0] TK_MUL_AS = 7'd35;
  localparam logic [6:0] TK_STAR   = 7'd36;
  localparam logic [6:0] TK_DIV_AS = 7'd37;
  localparam logic [6:0] TK_SLASH  = 7'd38;
  localparam logic [6:0] TK_MOD_AS = 7'd39;
  localparam logic [6:0] TK_PCT    = 7'd40;
  localparam logic [6:0] TK_LTE    = 7'd41;
  localparam logic [6:0] TK_LSH    = 7'd42;
  localparam logic [6:0] TK_LT     = 7'd43;
  localparam logic [6:0] TK_GTE    = 7'd44;
  localparam logic [6:0] TK_RSH    = 7'd45;
  localparam logic [6:0] TK_GT     = 7'd46;
  localparam logic [6:0] TK_EQ     = 7'd47;
  localparam logic [6:0] TK_ASSIGN = 7'd48;
  localparam logic [6:0] TK_NEQ    = 7'd49;
  localparam logic [6:0] TK_NOT    = 7'd50;
  localparam logic [6:0] TK_XOR_AS = 7'd51;
  localparam logic [6:0] TK_XOR    = 7'd52;
  localparam logic [6:0] TK_LAND   = 7'd53;
  localparam logic [6:0] TK_AND_AS = 7'd54;
  localparam logic [6:0] TK_AMP    = 7'd55;
  localparam logic [6:0] TK_LOR    = 7'd56;
  localparam logic [6:0] TK_OR_AS  = 7'd57;
  localparam logic [6:0] TK_BOR    = 7'd58;
  localparam logic [6:0] TK_AT     = 7'd59;
  localparam logic [6:0] TK_DOT    = 7'd60;
  localparam logic [6:0] TK_TILDE  = 7'd61;
  localparam logic [6:0] TK_COLON  = 7'd62;
  localparam logic [6:0] TK_SEMI   = 7'd63;
  localparam logic [6:0] TK_COMMA  = 7'd64;
  localparam logic [6:0] TK_LPAR   = 7'd65;
  localparam logic [6:0] TK_RPAR   = 7'd66;
  localparam logic [6:0] TK_LCUR   = 7'd67;
  localparam logic [6:0] TK_RCUR   = 7'd68;
  localparam logic [6:0] TK_LBRK   = 7'd69;
  localparam logic [6:0] TK_RBRK   = 7'd70;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } scan_in_t;

  typedef struct packed {
    logic                   record_kind;
    logic [6:0]             token_kind;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic [7:0]             text_byte;
    logic                   last_of_run;
  } scan_out_t;

  typedef scan_out_t [MAX_RESULTS-1:0] result_set_t;

endpackage

// ===== hw/rtl/sts_step.sv =====
// ---------------------------------------------------------------------------
// Scanner step
// Holds the scanner state and works out all beats caused by one character.
// ---------------------------------------------------------------------------
module sts_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  sts_pkg::scan_in_t   item,
  output sts_pkg::result_set_t res,
  output logic [1:0]          res_n
);

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_WORD      = 4'd1;
  localparam logic [3:0] M_NUM       = 4'd2;
  localparam logic [3:0] M_OP        = 4'd3;
  localparam logic [3:0] M_COMMENT   = 4'd4;
  localparam logic [3:0] M_STR       = 4'd5;
  localparam logic [3:0] M_STR_ESC   = 4'd6;
  localparam logic [3:0] M_CHR_OPEN  = 4'd7;
  localparam logic [3:0] M_CHR_ESC   = 4'd8;
  localparam logic [3:0] M_CHR_CLOSE = 4'd9;

  typedef struct packed {
    logic [3:0]                     mode;
    logic [7:0]                     pend_op;
    logic [63:0]                    kw_buf;
    logic [3:0]                     word_len;
    logic [sts_pkg::LINE_BITS-1:0]   line;
    logic [sts_pkg::COLUMN_BITS-1:0] col;
    logic [sts_pkg::COLUMN_BITS-1:0] tok_col;
    logic                           esc_fail;
    logic [7:0]                     char_val;
  } scan_state_t;

  typedef struct packed {
    scan_state_t       st;
    logic              consumed;
    logic [1:0]        n;
    sts_pkg::scan_out_t r0;
    sts_pkg::scan_out_t r1;
  } pass_t;

  scan_state_t state;
  scan_state_t state_next;

  function automatic sts_pkg::scan_out_t mk(logic rk, logic [6:0] kind,
                                           logic [sts_pkg::LINE_BITS-1:0] ln,
                                           logic [sts_pkg::COLUMN_BITS-1:0] cl,
                                           logic [7:0] b);
    sts_pkg::scan_out_t r;
    r.record_kind   = rk;
    r.token_kind    = kind;
    r.line_number   = ln;
    r.column_number = cl;
    r.text_byte     = b;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  // Bit 7 flags a valid operator.
  function automatic logic [7:0] single_kind(logic [7:0] p);
    logic [7:0] k;
    case (p)
      "+":     k = {1'b1, sts_pkg::TK_PLUS};
      "-":     k = {1'b1, sts_pkg::TK_MINUS};
      "*":     k = {1'b1, sts_pkg::TK_STAR};
      "/":     k = {1'b1, sts_pkg::TK_SLASH};
      "%":     k = {1'b1, sts_pkg::TK_PCT};
      "<":     k = {1'b1, sts_pkg::TK_LT};
      ">":     k = {1'b1, sts_pkg::TK_GT};
      "=":     k = {1'b1, sts_pkg::TK_ASSIGN};
      "!":     k = {1'b1, sts_pkg::TK_NOT};
      "^":     k = {1'b1, sts_pkg::TK_XOR};
      "&":     k = {1'b1, sts_pkg::TK_AMP};
      "|":     k = {1'b1, sts_pkg::TK_BOR};
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] pair_kind(logic [7:0] p, logic [7:0] c);
    logic [7:0] k;
    k = 8'h00;
    if (c == "=") begin
      case (p)
        "+":     k = {1'b1, sts_pkg::TK_ADD_AS};
        "-":     k = {1'b1, sts_pkg::TK_SUB_AS};
        "*":     k = {1'b1, sts_pkg::TK_MUL_AS};
        "/":     k = {1'b1, sts_pkg::TK_DIV_AS};
        "%":     k = {1'b1, sts_pkg::TK_MOD_AS};
        "<":     k = {1'b1, sts_pkg::TK_LTE};
        ">":     k = {1'b1, sts_pkg::TK_GTE};
        "=":     k = {1'b1, sts_pkg::TK_EQ};
        "!":     k = {1'b1, sts_pkg::TK_NEQ};
        "^":     k = {1'b1, sts_pkg::TK_XOR_AS};
        "&":     k = {1'b1, sts_pkg::TK_AND_AS};
        "|":     k = {1'b1, sts_pkg::TK_OR_AS};
        default: k = 8'h00;
      endcase
    end else if (p == "-" && c == ">") begin
      k = {1'b1, sts_pkg::TK_ARROW};
    end else if (p == "<" && c == "<") begin
      k = {1'b1, sts_pkg::TK_LSH};
    end else if (p == ">" && c == ">") begin
      k = {1'b1, sts_pkg::TK_RSH};
    end else if (p == "&" && c == "&") begin
      k = {1'b1, sts_pkg::TK_LAND};
    end else if (p == "|" && c == "|") begin
      k = {1'b1, sts_pkg::TK_LOR};
    end
    return k;
  endfunction

  function automatic logic [6:0] op_or_error(logic [7:0] p);
    logic [7:0] k;
    k = single_kind(p);
    return k[7] ? k[6:0] : sts_pkg::TK_ERROR;
  endfunction

  // Bit 8 flags a known escape.
  function automatic logic [8:0] escape_value(logic [7:0] x, logic [7:0] quote);
    logic [8:0] v;
    v = 9'h000;
    if (x == "n") v = {1'b1, 8'h0A};
    else if (x == "\\") v = {1'b1, 8'h5C};
    else if (x == quote) v = {1'b1, quote};
    else if (x == "0") v = {1'b1, 8'h00};
    return v;
  endfunction

  function automatic logic [63:0] kw_word(int i);
    logic [63:0] w;
    case (i)
      0:       w = "i32";
      1:       w = "let";
      2:       w = "if";
      3:       w = "true";
      4:       w = "false";
      5:       w = "i64";
      6:       w = "u32";
      7:       w = "u64";
      8:       w = "usize";
      9:       w = "const";
      10:      w = "break";
      11:      w = "continue";
      12:      w = "else";
      13:      w = "void";
      14:      w = "char";
      15:      w = "return";
      16:      w = "while";
      17:      w = "bool";
      18:      w = "struct";
      19:      w = "asm";
      20:      w = "sizeof";
      21:      w = "cast";
      22:      w = "null";
      23:      w = "proto";
      default: w = '1;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] word_kind(logic [63:0] buf_v, logic [3:0] len);
    logic [6:0] k;
    k = sts_pkg::TK_IDENT;
    if (len <= 4'd8) begin
      for (int i = 0; i < 24; i++) begin
        if (kw_word(i) == buf_v) k = sts_pkg::TK_KW0 + 7'(i);
      end
    end
    return k;
  endfunction

  function automatic scan_state_t word_add(scan_state_t s, logic [7:0] c);
    scan_state_t t;
    t = s;
    if (s.word_len < 4'd8) t.kw_buf = {s.kw_buf[55:0], c};
    if (s.word_len < 4'd15) t.word_len = s.word_len + 4'd1;
    return t;
  endfunction

  function automatic pass_t scan_pass(scan_state_t s, logic [7:0] c);
    pass_t      p;
    logic [7:0] k;
    logic [8:0] e;
    p.st       = s;
    p.consumed = 1'b1;
    p.n        = 2'd0;
    p.r0       = '0;
    p.r1       = '0;
    case (s.mode)
      M_IDLE: begin
        if (!is_space(c)) begin
          p.st.tok_col = s.col;
          p.n = 2'd1;
          if (is_alpha(c) || c == "_") begin
            p.st.mode     = M_WORD;
            p.st.kw_buf   = {56'd0, c};
            p.st.word_len = 4'd1;
            p.r0 = mk(1'b0, sts_pkg::TK_IDENT, s.line, s.col, c);
          end else if (is_digit(c)) begin
            p.st.mode = M_NUM;
            p.r0 = mk(1'b0, sts_pkg::TK_INT, s.line, s.col, c);
          end else if (c == "'") begin
            p.st.mode = M_CHR_OPEN;
            p.st.esc_fail = 1'b0;
            p.n = 2'd0;
          end else if (c == "\"") begin
            p.st.mode = M_STR;
            p.st.esc_fail = 1'b0;
            p.n = 2'd0;
          end else if (single_kind(c) != 8'h00) begin
            p.st.mode = M_OP;
            p.st.pend_op = c;
            p.n = 2'd0;
          end else begin
            case (c)
              "@":     k = {1'b0, sts_pkg::TK_AT};
              ".":     k = {1'b0, sts_pkg::TK_DOT};
              "~":     k = {1'b0, sts_pkg::TK_TILDE};
              ":":     k = {1'b0, sts_pkg::TK_COLON};
              ";":     k = {1'b0, sts_pkg::TK_SEMI};
              ",":     k = {1'b0, sts_pkg::TK_COMMA};
              "(":     k = {1'b0, sts_pkg::TK_LPAR};
              ")":     k = {1'b0, sts_pkg::TK_RPAR};
              "{":     k = {1'b0, sts_pkg::TK_LCUR};
              "}":     k = {1'b0, sts_pkg::TK_RCUR};
              "[":     k = {1'b0, sts_pkg::TK_LBRK};
              "]":     k = {1'b0, sts_pkg::TK_RBRK};
              default: k = {1'b0, sts_pkg::TK_ERROR};
            endcase
            p.r0 = mk(1'b1, k[6:0], s.line, s.col, 8'h00);
          end
        end
      end
      M_WORD: begin
        p.n = 2'd1;
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          p.st = word_add(s, c);
          p.r0 = mk(1'b0, sts_pkg::TK_IDENT, s.line, s.tok_col, c);
        end else begin
          p.r0 = mk(1'b1, word_kind(s.kw_buf, s.word_len), s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
          p.consumed = 1'b0;
        end
      end
      M_NUM: begin
        p.n = 2'd1;
        if (is_digit(c)) begin
          p.r0 = mk(1'b0, sts_pkg::TK_INT, s.line, s.tok_col, c);
        end else begin
          p.r0 = mk(1'b1, sts_pkg::TK_INT, s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
          p.consumed = 1'b0;
        end
      end
      M_OP: begin
        k = pair_kind(s.pend_op, c);
        if (k[7]) begin
          p.n = 2'd1;
          p.r0 = mk(1'b1, k[6:0], s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
        end else if (s.pend_op == "-" && is_digit(c)) begin
          p.n = 2'd2;
          p.st.mode = M_NUM;
          p.r0 = mk(1'b0, sts_pkg::TK_INT, s.line, s.tok_col, "-");
          p.r1 = mk(1'b0, sts_pkg::TK_INT, s.line, s.tok_col, c);
        end else if (s.pend_op == "/" && c == "/") begin
          // The column counter parks on the first slash for the whole comment.
          p.st.mode = M_COMMENT;
          p.st.col = s.tok_col;
        end else begin
          p.n = 2'd1;
          p.r0 = mk(1'b1, op_or_error(s.pend_op), s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
          p.consumed = 1'b0;
        end
      end
      M_COMMENT: begin
        if (c == 8'h0A) begin
          p.st.mode = M_IDLE;
          p.consumed = 1'b0;
        end
      end
      M_STR: begin
        if (c == "\"") begin
          p.n = 2'd1;
          p.r0 = mk(1'b1, s.esc_fail ? sts_pkg::TK_ERROR : sts_pkg::TK_STR,
                    s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
        end else if (c == 8'h0A) begin
          p.n = 2'd1;
          p.r0 = mk(1'b1, sts_pkg::TK_ERROR, s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
          p.consumed = 1'b0;
        end else if (c == "\\") begin
          p.st.mode = M_STR_ESC;
        end else begin
          p.n = 2'd1;
          p.r0 = mk(1'b0, sts_pkg::TK_STR, s.line, s.tok_col, c);
        end
      end
      M_STR_ESC: begin
        e = escape_value(c, "\"");
        p.st.mode = M_STR;
        p.n = 2'd1;
        if (!e[8]) begin
          p.st.esc_fail = 1'b1;
          p.r0 = mk(1'b0, sts_pkg::TK_STR, s.line, s.tok_col, "E");
          p.consumed = (c != 8'h0A);
        end else begin
          p.r0 = mk(1'b0, sts_pkg::TK_STR, s.line, s.tok_col, e[7:0]);
        end
      end
      M_CHR_OPEN: begin
        if (c == 8'h0A) begin
          p.n = 2'd1;
          p.r0 = mk(1'b1, sts_pkg::TK_ERROR, s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
          p.consumed = 1'b0;
        end else if (c == "\\") begin
          p.st.mode = M_CHR_ESC;
        end else if (c == "'") begin
          p.n = 2'd1;
          p.r0 = mk(1'b1, sts_pkg::TK_ERROR, s.line, s.tok_col, 8'h00);
          p.st.mode = M_IDLE;
        end else begin
          p.st.char_val = c;
          p.st.mode = M_CHR_CLOSE;
        end
      end
      M_CHR_ESC: begin
        e = escape_value(c, "'");
        p.st.mode = M_CHR_CLOSE;
        if (!e[8]) begin
          p.st.esc_fail = 1'b1;
          p.st.char_val = "E";
          p.consumed = (c != 8'h0A);
        end else begin
          p.st.char_val = e[7:0];
        end
      end
      M_CHR_CLOSE: begin
        p.st.mode = M_IDLE;
        p.n = 2'd1;
        if (c == "'") begin
          if (s.esc_fail) begin
            p.r0 = mk(1'b1, sts_pkg::TK_ERROR, s.line, s.tok_col, 8'h00);
          end else begin
            p.n = 2'd2;
            p.r0 = mk(1'b0, sts_pkg::TK_CHR, s.line, s.tok_col, s.char_val);
            p.r1 = mk(1'b1, sts_pkg::TK_CHR, s.line, s.tok_col, 8'h00);
          end
        end else begin
          p.r0 = mk(1'b1, sts_pkg::TK_ERROR, s.line, s.tok_col, 8'h00);
          p.consumed = 1'b0;
        end
      end
      default: begin
        p.st.mode = M_IDLE;
        p.consumed = 1'b0;
      end
    endcase
    return p;
  endfunction

  // A byte is rescanned at most twice: an escape cut by a newline falls back
  // to the literal, which then closes with ERROR and leaves the newline to idle.
  pass_t p1, p2, p3;
  sts_pkg::scan_out_t cand [6];
  logic [1:0]         cand_n [3];
  logic [2:0]         n_acc;
  sts_pkg::result_set_t res_w;
  scan_state_t        s_end;

  always_comb begin
    p1 = scan_pass(state, item.ch);
    p2 = scan_pass(p1.st, item.ch);
    p3 = scan_pass(p2.st, item.ch);
    cand[0] = p1.r0;
    cand[1] = p1.r1;
    cand[2] = p2.r0;
    cand[3] = p2.r1;
    cand[4] = p3.r0;
    cand[5] = p3.r1;
    cand_n[0] = p1.n;
    cand_n[1] = p1.consumed ? 2'd0 : p2.n;
    cand_n[2] = (p1.consumed || p2.consumed) ? 2'd0 : p3.n;
    res_w = '0;
    n_acc = 3'd0;
    s_end = state;
    state_next = state;
    if (item.end_of_input) begin
      s_end.mode = M_IDLE;
      case (state.mode)
        M_WORD: begin
          res_w[0] = mk(1'b1, word_kind(state.kw_buf, state.word_len), state.line,
                        state.tok_col, 8'h00);
          n_acc = 3'd1;
        end
        M_NUM: begin
          res_w[0] = mk(1'b1, sts_pkg::TK_INT, state.line, state.tok_col, 8'h00);
          n_acc = 3'd1;
        end
        M_OP: begin
          res_w[0] = mk(1'b1, op_or_error(state.pend_op), state.line, state.tok_col,
                        8'h00);
          n_acc = 3'd1;
        end
        M_STR, M_STR_ESC, M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE: begin
          res_w[0] = mk(1'b1, sts_pkg::TK_ERROR, state.line, state.tok_col, 8'h00);
          n_acc = 3'd1;
        end
        default: n_acc = 3'd0;
      endcase
      res_w[n_acc[1:0]] = mk(1'b1, sts_pkg::TK_EOF, state.line, state.col, 8'h00);
      n_acc = n_acc + 3'd1;
      state_next = s_end;
    end else begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (2'(j) < cand_n[i] && n_acc < 3'd3) begin
            res_w[n_acc[1:0]] = cand[2*i+j];
            n_acc = n_acc + 3'd1;
          end
        end
      end
      state_next = p1.consumed ? p1.st : (p2.consumed ? p2.st : p3.st);
      if (item.ch == 8'h0A) begin
        if (state_next.line != '1) state_next.line = state_next.line + 1'b1;
        state_next.col = sts_pkg::COLUMN_BITS'(1);
      end else if (state_next.mode != M_COMMENT) begin
        if (state_next.col != '1) state_next.col = state_next.col + 1'b1;
      end
    end
    if (n_acc != 3'd0) res_w[n_acc[1:0] - 2'd1].last_of_run = 1'b1;
  end

  assign res   = res_w;
  assign res_n = n_acc[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode     <= M_IDLE;
      state.pend_op  <= 8'h00;
      state.kw_buf   <= 64'd0;
      state.word_len <= 4'd0;
      state.line     <= sts_pkg::LINE_BITS'(1);
      state.col      <= sts_pkg::COLUMN_BITS'(1);
      state.tok_col  <= sts_pkg::COLUMN_BITS'(1);
      state.esc_fail <= 1'b0;
      state.char_val <= 8'h00;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/sts_fifo.sv =====
// ---------------------------------------------------------------------------
// Result queue
// Takes up to three beats per cycle, hands out one per cycle unless stalled.
// ---------------------------------------------------------------------------
module sts_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sts_pkg::result_set_t wr_data,
  input  logic [1:0]           wr_n,
  output logic                 room,
  output logic                 rd_valid,
  input  logic                 rd_stall,
  output sts_pkg::scan_out_t   rd_data
);

  localparam int DEPTH = 8;
  localparam int AW    = $clog2(DEPTH);

  sts_pkg::scan_out_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   cnt;
  logic          pop;
  logic [AW:0]   add_n;

  assign pop      = rd_valid && !rd_stall;
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rd_ptr];
  assign room     = (cnt <= (AW+1)'(DEPTH - sts_pkg::MAX_RESULTS));
  assign add_n    = push ? (AW+1)'(wr_n) : '0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < sts_pkg::MAX_RESULTS; i++) begin
      if (push && 2'(i) < wr_n) mem[wr_ptr + AW'(i)] <= wr_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + add_n[AW-1:0];
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + add_n - (AW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= (AW+1)'(DEPTH))
    else $error("result queue overfilled");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("push without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == cnt[AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/source_token_scanner_core.sv =====
// ---------------------------------------------------------------------------
// Source token scanner
// Streaming lexer: one source byte per beat in, token records and text out.
// ---------------------------------------------------------------------------
// A byte is registered and scanned once the result queue has room; its beats
// are written into the queue. Throughput: one byte per cycle while the queue
// has room, bounded by the single output port that drains the queue at one
// beat per cycle unless stalled (up to three beats per byte).
// Reset: synchronous; the scanner returns to idle at line 1, column 1.
module source_token_scanner_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  sts_pkg::scan_in_t  char_item,
  output logic               tok_valid,
  input  logic               tok_stall,
  output sts_pkg::scan_out_t tok_item
);

  logic                 in_vld;
  sts_pkg::scan_in_t    in_item;
  logic                 room;
  logic                 process;
  sts_pkg::result_set_t res;
  logic [1:0]           res_n;

  assign process    = in_vld && room;
  assign char_stall = in_vld && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= (char_valid && !char_stall) || (in_vld && !process);
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) in_item <= char_item;
  end

  sts_step u_step (
    .clk   (clk),
    .rst   (rst),
    .fire  (process),
    .item  (in_item),
    .res   (res),
    .res_n (res_n)
  );

  sts_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (process),
    .wr_data  (res),
    .wr_n     (res_n),
    .room     (room),
    .rd_valid (tok_valid),
    .rd_stall (tok_stall),
    .rd_data  (tok_item)
  );

  a_eof_beat: assert property (@(posedge clk) disable iff (rst)
    process && in_item.end_of_input |-> res_n != 2'd0)
    else $error("end marker produced no beat");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> in_vld)
    else $error("stall raised with no byte held");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    process && res_n != 2'd0 |-> res[res_n - 2'd1].last_of_run)
    else $error("final beat of a byte lacks its last flag");

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Source token scanner testbench
// Feeds source bytes and end markers into the scanner, predicts every result
// beat with a behavioral lexer model and compares each output beat in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 50000;
  localparam logic [sts_pkg::LINE_BITS-1:0]   LINE_TOP = '1;
  localparam logic [sts_pkg::COLUMN_BITS-1:0] COL_TOP  = '1;

  typedef enum logic [3:0] {
    SM_IDLE, SM_WORD, SM_NUM, SM_OP, SM_COMMENT, SM_STR, SM_STR_ESC,
    SM_CHR_OPEN, SM_CHR_ESC, SM_CHR_CLOSE
  } scan_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  sts_pkg::scan_in_t char_item = '0;
  logic tok_valid;
  logic tok_stall = 1'b1;
  sts_pkg::scan_out_t tok_item;

  source_token_scanner_core u_top (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
    .tok_valid(tok_valid), .tok_stall(tok_stall), .tok_item(tok_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Lexer state mirrored by the predictor.
  scan_mode_t                      lx_mode;
  logic [7:0]                      lx_pend_op;
  logic [63:0]                     lx_word_bits;
  logic [3:0]                      lx_word_len;
  logic [sts_pkg::LINE_BITS-1:0]   lx_line;
  logic [sts_pkg::COLUMN_BITS-1:0] lx_col;
  logic [sts_pkg::COLUMN_BITS-1:0] lx_start_col;
  logic                            lx_bad_esc;
  logic [7:0]                      lx_char_val;
  int                              lx_beats_this_byte;

  sts_pkg::scan_out_t pending_beats[$];
  int  error_count = 0;
  int  beats_seen = 0;
  int  records_seen = 0;
  int  bytes_sent = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;
  bit  no_gaps = 1'b0;

  function automatic logic [63:0] kw_bits(input int idx);
    string words[24] = '{"i32", "let", "if", "true", "false", "i64", "u32",
      "u64", "usize", "const", "break", "continue", "else", "void", "char",
      "return", "while", "bool", "struct", "asm", "sizeof", "cast", "null",
      "proto"};
    logic [63:0] v;
    v = '0;
    for (int j = 0; j < words[idx].len(); j++) v = (v << 8) | words[idx][j];
    return v;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int single_op(input logic [7:0] p);
    case (p)
      "+": return sts_pkg::TK_PLUS;   "-": return sts_pkg::TK_MINUS;
      "*": return sts_pkg::TK_STAR;   "/": return sts_pkg::TK_SLASH;
      "%": return sts_pkg::TK_PCT;    "<": return sts_pkg::TK_LT;
      ">": return sts_pkg::TK_GT;     "=": return sts_pkg::TK_ASSIGN;
      "!": return sts_pkg::TK_NOT;    "^": return sts_pkg::TK_XOR;
      "&": return sts_pkg::TK_AMP;    "|": return sts_pkg::TK_BOR;
      default: return -1;
    endcase
  endfunction

  function automatic int pair_op(input logic [7:0] p, input logic [7:0] c);
    if (c == "=") begin
      case (p)
        "+": return sts_pkg::TK_ADD_AS; "-": return sts_pkg::TK_SUB_AS;
        "*": return sts_pkg::TK_MUL_AS; "/": return sts_pkg::TK_DIV_AS;
        "%": return sts_pkg::TK_MOD_AS; "<": return sts_pkg::TK_LTE;
        ">": return sts_pkg::TK_GTE;    "=": return sts_pkg::TK_EQ;
        "!": return sts_pkg::TK_NEQ;    "^": return sts_pkg::TK_XOR_AS;
        "&": return sts_pkg::TK_AND_AS; "|": return sts_pkg::TK_OR_AS;
        default: return -1;
      endcase
    end
    if (p == "-" && c == ">") return sts_pkg::TK_ARROW;
    if (p == "<" && c == "<") return sts_pkg::TK_LSH;
    if (p == ">" && c == ">") return sts_pkg::TK_RSH;
    if (p == "&" && c == "&") return sts_pkg::TK_LAND;
    if (p == "|" && c == "|") return sts_pkg::TK_LOR;
    return -1;
  endfunction

  function automatic int punct_kind(input logic [7:0] c);
    logic [7:0] marks[12] = '{"@", ".", "~", ":", ";", ",", "(", ")", "{", "}",
      "[", "]"};
    for (int i = 0; i < 12; i++) if (marks[i] == c) return sts_pkg::TK_AT + i;
    return -1;
  endfunction

  function automatic int escape_of(input logic [7:0] x, input logic [7:0] q);
    if (x == "n") return 8'h0a;
    if (x == "\\") return 8'h5c;
    if (x == q) return q;
    if (x == "0") return 0;
    return -1;
  endfunction

  function automatic logic [6:0] word_token();
    if (lx_word_len > 8) return sts_pkg::TK_IDENT;
    for (int i = 0; i < 24; i++)
      if (kw_bits(i) == lx_word_bits) return sts_pkg::TK_KW0 + 7'(i);
    return sts_pkg::TK_IDENT;
  endfunction

  task automatic push_beat(input logic rk, input logic [6:0] kind,
                           input logic [sts_pkg::COLUMN_BITS-1:0] col,
                           input logic [7:0] b);
    sts_pkg::scan_out_t r;
    if (lx_beats_this_byte >= sts_pkg::MAX_RESULTS) return;
    r.record_kind = rk;
    r.token_kind = kind;
    r.line_number = lx_line;
    r.column_number = col;
    r.text_byte = b;
    r.last_of_run = 1'b0;
    pending_beats.push_back(r);
    lx_beats_this_byte++;
  endtask

  task automatic push_record(input int kind);
    push_beat(1'b1, kind[6:0], lx_start_col, 8'h00);
  endtask

  task automatic push_text(input logic [6:0] kind, input logic [7:0] b);
    push_beat(1'b0, kind, lx_start_col, b);
  endtask

  task automatic word_append(input logic [7:0] c);
    if (lx_word_len < 8) lx_word_bits = (lx_word_bits << 8) | c;
    if (lx_word_len < 15) lx_word_len++;
  endtask

  // Returns 1 when the byte is consumed, 0 when it must be scanned again.
  task automatic scan_one(input logic [7:0] c, output bit consumed);
    int k;
    consumed = 1'b1;
    case (lx_mode)
      SM_IDLE: begin
        if (c == " " || (c >= 9 && c <= 13)) return;
        lx_start_col = lx_col;
        if (is_alpha(c) || c == "_") begin
          lx_mode = SM_WORD;
          lx_word_bits = '0;
          lx_word_len = '0;
          word_append(c);
          push_text(sts_pkg::TK_IDENT, c);
        end else if (is_digit(c)) begin
          lx_mode = SM_NUM;
          push_text(sts_pkg::TK_INT, c);
        end else if (c == "'") begin
          lx_mode = SM_CHR_OPEN;
          lx_bad_esc = 1'b0;
        end else if (c == "\"") begin
          lx_mode = SM_STR;
          lx_bad_esc = 1'b0;
        end else if (single_op(c) >= 0) begin
          lx_mode = SM_OP;
          lx_pend_op = c;
        end else begin
          k = punct_kind(c);
          push_record(k >= 0 ? k : sts_pkg::TK_ERROR);
        end
      end
      SM_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          word_append(c);
          push_text(sts_pkg::TK_IDENT, c);
        end else begin
          push_record(word_token());
          lx_mode = SM_IDLE;
          consumed = 1'b0;
        end
      end
      SM_NUM: begin
        if (is_digit(c)) push_text(sts_pkg::TK_INT, c);
        else begin
          push_record(sts_pkg::TK_INT);
          lx_mode = SM_IDLE;
          consumed = 1'b0;
        end
      end
      SM_OP: begin
        k = pair_op(lx_pend_op, c);
        if (k >= 0) begin
          push_record(k);
          lx_mode = SM_IDLE;
        end else if (lx_pend_op == "-" && is_digit(c)) begin
          lx_mode = SM_NUM;
          push_text(sts_pkg::TK_INT, "-");
          push_text(sts_pkg::TK_INT, c);
        end else if (lx_pend_op == "/" && c == "/") begin
          lx_mode = SM_COMMENT;
          lx_col = lx_start_col;
        end else begin
          k = single_op(lx_pend_op);
          push_record(k >= 0 ? k : sts_pkg::TK_ERROR);
          lx_mode = SM_IDLE;
          consumed = 1'b0;
        end
      end
      SM_COMMENT: begin
        if (c == 8'h0a) begin
          lx_mode = SM_IDLE;
          consumed = 1'b0;
        end
      end
      SM_STR: begin
        if (c == "\"") begin
          push_record(lx_bad_esc ? sts_pkg::TK_ERROR : sts_pkg::TK_STR);
          lx_mode = SM_IDLE;
        end else if (c == 8'h0a) begin
          push_record(sts_pkg::TK_ERROR);
          lx_mode = SM_IDLE;
          consumed = 1'b0;
        end else if (c == "\\") lx_mode = SM_STR_ESC;
        else push_text(sts_pkg::TK_STR, c);
      end
      SM_STR_ESC: begin
        k = escape_of(c, "\"");
        lx_mode = SM_STR;
        if (k < 0) begin
          lx_bad_esc = 1'b1;
          push_text(sts_pkg::TK_STR, "E");
          consumed = (c != 8'h0a);
        end else push_text(sts_pkg::TK_STR, k[7:0]);
      end
      SM_CHR_OPEN: begin
        if (c == 8'h0a) begin
          push_record(sts_pkg::TK_ERROR);
          lx_mode = SM_IDLE;
          consumed = 1'b0;
        end else if (c == "\\") lx_mode = SM_CHR_ESC;
        else if (c == "'") begin
          push_record(sts_pkg::TK_ERROR);
          lx_mode = SM_IDLE;
        end else begin
          lx_char_val = c;
          lx_mode = SM_CHR_CLOSE;
        end
      end
      SM_CHR_ESC: begin
        k = escape_of(c, "'");
        lx_mode = SM_CHR_CLOSE;
        if (k < 0) begin
          lx_bad_esc = 1'b1;
          lx_char_val = "E";
          consumed = (c != 8'h0a);
        end else lx_char_val = k[7:0];
      end
      default: begin
        lx_mode = SM_IDLE;
        if (c == "'") begin
          if (lx_bad_esc) push_record(sts_pkg::TK_ERROR);
          else begin
            push_text(sts_pkg::TK_CHR, lx_char_val);
            push_record(sts_pkg::TK_CHR);
          end
        end else begin
          push_record(sts_pkg::TK_ERROR);
          consumed = 1'b0;
        end
      end
    endcase
  endtask

  task automatic predict_beats(input sts_pkg::scan_in_t it);
    bit consumed;
    int k;
    lx_beats_this_byte = 0;
    if (it.end_of_input) begin
      case (lx_mode)
        SM_WORD: push_record(word_token());
        SM_NUM:  push_record(sts_pkg::TK_INT);
        SM_OP: begin
          k = single_op(lx_pend_op);
          push_record(k >= 0 ? k : sts_pkg::TK_ERROR);
        end
        SM_IDLE, SM_COMMENT: ;
        default: push_record(sts_pkg::TK_ERROR);
      endcase
      lx_mode = SM_IDLE;
      push_beat(1'b1, sts_pkg::TK_EOF, lx_col, 8'h00);
    end else begin
      for (int g = 0; g < 4; g++) begin
        scan_one(it.ch, consumed);
        if (consumed) begin
          if (it.ch == 8'h0a) begin
            if (lx_line != LINE_TOP) lx_line++;
            lx_col = 1;
          end else if (lx_mode != SM_COMMENT && lx_col != COL_TOP) lx_col++;
          break;
        end
      end
    end
    if (lx_beats_this_byte > 0)
      pending_beats[pending_beats.size() - 1].last_of_run = 1'b1;
  endtask

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sender: one beat in, predicted as it is accepted. Valid stays up between
  // back-to-back beats and drops only for a gap or a drain.
  task automatic send_byte(input logic [7:0] c, input bit eoi = 1'b0);
    sts_pkg::scan_in_t it;
    int g;
    g = gap_len();
    if (g > 0) begin
      char_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.ch = c;
    it.end_of_input = eoi;
    char_item <= it;
    char_valid <= 1'b1;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    predict_beats(it);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain();
    char_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver stall pattern: mostly short holds, now and then a long one.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) tok_stall <= 1'b1;
      else if (no_gaps) tok_stall <= 1'b0;
      else if (stall_left > 0) begin
        tok_stall <= 1'b1;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) tok_stall <= 1'b0;
        else if (r < 97) begin
          tok_stall <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          tok_stall <= 1'b1;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Result checker.
  initial begin
    sts_pkg::scan_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && tok_valid && !tok_stall) begin
        beats_seen++;
        if (pending_beats.size() == 0) begin
          $error("unexpected result beat kind=%0d", tok_item.token_kind);
          error_count++;
        end else begin
          want = pending_beats.pop_front();
          if (tok_item.record_kind) records_seen++;
          if (tok_item.record_kind !== want.record_kind) begin
            $error("record_kind exp %0d got %0d", want.record_kind, tok_item.record_kind);
            error_count++;
          end
          if (tok_item.token_kind !== want.token_kind) begin
            $error("token_kind exp %0d got %0d", want.token_kind, tok_item.token_kind);
            error_count++;
          end
          if (tok_item.line_number !== want.line_number) begin
            $error("line_number exp %0d got %0d", want.line_number, tok_item.line_number);
            error_count++;
          end
          if (tok_item.column_number !== want.column_number) begin
            $error("column_number exp %0d got %0d", want.column_number,
                   tok_item.column_number);
            error_count++;
          end
          if (tok_item.text_byte !== want.text_byte) begin
            $error("text_byte exp %0d got %0d", want.text_byte, tok_item.text_byte);
            error_count++;
          end
          if (tok_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run exp %0d got %0d", want.last_of_run, tok_item.last_of_run);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_keywords_and_words();
    send_text("i32 let if true false i64 u32 u64 usize const break continue\n");
    send_text("else void char return while bool struct asm sizeof cast null proto\n");
    send_text("_x9 Zz abcdefghijklmnop continuex protocol\n");
  endtask

  task automatic test_operators();
    send_text("+= + -= -> - *= * /= / %= % <= << < >= >> > == = != ! ^= ^\n");
    send_text("&& &= & || |= | @.~:;,()}{[] -42 x-7 0 9876543210\n");
    send_text("a/ / b // comment here ~\nq");
    send_end();
  endtask

  task automatic test_literals();
    send_text("\"ab\\n\\\\\\0\\\"\" \"bad\\q\" \"open\n\"x\\\n");
    send_text("'a' '\\'' '\\n' '' 'ab' '\n'\\z' '\\\n");
    send_byte(8'h80); send_byte(8'hff); send_byte(8'h00); send_byte("$");
    send_text("\"tail"); send_end();
    send_text("'"); send_end();
    send_text("'x"); send_end();
    send_text("'\\"); send_end();
    send_text("\"e\\"); send_end();
    send_end();
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_text("while (x >= -12) { y = y << 3; }\n");
    join
    drain();
  endtask

  // Bytes offered on every cycle with the receiver always ready.
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    send_text("let v1 = a_b + 22; 'q' \"s\\n\" -7>=x\n");
    send_end();
    drain();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_text();
    string pieces[24] = '{"while", "i32", "proto", "x", "_tmp1", "12", "-5",
      "\"s\\n\"", "'c'", "'\\0'", "->", "<<=", "==", "!=", "&&", "||", "//c\n",
      "(", ")", ";", "\n", " ", "\t", "\"q\\w\""};
    int r;
    for (int n = 0; n < 30; n++) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_text(pieces[$urandom_range(0, 23)]);
      else if (r < 95) send_byte(8'($urandom_range(0, 255)));
      else if (r < 98) send_byte(8'($urandom_range(32, 126)));
      else send_end();
    end
    send_end();
    drain();
  endtask

  initial begin
    lx_mode = SM_IDLE; lx_pend_op = '0; lx_word_bits = '0; lx_word_len = '0;
    lx_line = 1; lx_col = 1; lx_start_col = 1; lx_bad_esc = 1'b0; lx_char_val = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_keywords_and_words();
    test_operators();
    test_literals();
    test_backpressure();
    test_back_to_back();
    test_random_text();
    $display("Sent %0d source beats; checked %0d result beats, %0d token records.",
             bytes_sent, beats_seen, records_seen);
    $display("Covered keywords, operators, literals, escapes, errors, end markers, stalls.");
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sts_pkg.sv
hw/rtl/sts_step.sv
hw/rtl/sts_fifo.sv
hw/rtl/source_token_scanner_core.sv
test/testbench.sv
